@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ design/sspp_pkg.sv @@
`timescale 1ns / 1ps

package sspp_pkg;

    // Default sizing of the skyline store.
    localparam int WIDTH_MAX_DEF   = 256;
    localparam int HEIGHT_BITS_DEF = 16;

    // Field widths of the channels and the register.
    localparam int STRIP_W_BITS = 9;
    localparam int PIECE_W_BITS = 9;
    localparam int PIECE_H_BITS = 16;
    localparam int X_BITS       = 8;
    localparam int Y_BITS       = 16;
    localparam int PEAK_BITS    = 16;
    localparam int STATUS_BITS  = 2;

    localparam logic [STRIP_W_BITS-1:0] STRIP_W_RESET = 9'd256;

    localparam logic [STATUS_BITS-1:0] STATUS_PLACED    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_TOO_WIDE  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_SATURATED = 2'd2;

endpackage

@@ design/sspp_if.sv @@
`timescale 1ns / 1ps

interface sspp_in_if import sspp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    new_layout;
    logic [PIECE_W_BITS-1:0] piece_width;
    logic [PIECE_H_BITS-1:0] piece_height;
    logic                    rotated;

    modport source (output valid, new_layout, piece_width, piece_height, rotated,
                    input ready);
    modport sink   (input valid, new_layout, piece_width, piece_height, rotated,
                    output ready);
endinterface

interface sspp_out_if import sspp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [X_BITS-1:0]      place_x;
    logic [Y_BITS-1:0]      place_y;
    logic [PEAK_BITS-1:0]   peak_height;
    logic [STATUS_BITS-1:0] status;

    modport source (output valid, place_x, place_y, peak_height, status,
                    input ready);
    modport sink   (input valid, place_x, place_y, peak_height, status,
                    output ready);
endinterface

@@ design/sspp_ram.sv @@
`timescale 1ns / 1ps

module sspp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/skyline_strip_packing_placer_core.sv @@
// Flow: an accepted item scans the strip columns, then its chosen span (base pass), computes its top
// and writes the span; a too-wide piece stops after the first scan, a piece with new_layout set skips
// both scans and rewrites the whole store, and a result waits while an earlier one still blocks the output.
// Throughput: one item at a time; the input is ready again in the cycle its result appears.
// Reset: a clear pass zeroes all WIDTH_MAX column heights first; strip_width resets to 256.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skyline_strip_packing_placer_core import sspp_pkg::*; #(
    parameter int WIDTH_MAX   = WIDTH_MAX_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [STRIP_W_BITS-1:0] cfg_wdata,
    sspp_in_if.sink                 req,
    sspp_out_if.source              rsp
);

    localparam int CW  = $clog2(WIDTH_MAX);
    localparam int SWW = $clog2(WIDTH_MAX + 1);
    localparam int TW  = ((HEIGHT_BITS > PIECE_H_BITS) ? HEIGHT_BITS : PIECE_H_BITS) + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_BASE  = 3'd3;
    localparam logic [2:0] S_CALC  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_FILL  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [HEIGHT_BITS-1:0] HMAX = {HEIGHT_BITS{1'b1}};

    // Control state
    logic [2:0]              state_reg, state_next;
    logic [SWW-1:0]          cnt_reg, cnt_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic                    rd_last_reg, rd_last_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STRIP_W_BITS-1:0] strip_width_reg;

    // Per-item working registers
    logic [CW-1:0]           rd_addr_reg, rd_addr_next;
    logic [SWW-1:0]          w_reg, w_next;
    logic [PIECE_H_BITS-1:0] h_reg, h_next;
    logic [SWW-1:0]          sw_reg, sw_next;
    logic [SWW-1:0]          lim_reg, lim_next;
    logic                    fits_reg, fits_next;
    logic                    clear_reg, clear_next;
    logic [CW-1:0]           best_reg, best_next;
    logic [HEIGHT_BITS-1:0]  best_h_reg, best_h_next;
    logic [HEIGHT_BITS-1:0]  peak_reg, peak_next;
    logic [HEIGHT_BITS-1:0]  base_reg, base_next;
    logic [HEIGHT_BITS-1:0]  top_reg, top_next;
    logic                    sat_reg, sat_next;

    logic [X_BITS-1:0]       out_x_reg, out_x_next;
    logic [Y_BITS-1:0]       out_y_reg, out_y_next;
    logic [PEAK_BITS-1:0]    out_peak_reg, out_peak_next;
    logic [STATUS_BITS-1:0]  out_status_reg, out_status_next;

    // Column RAM ports
    logic                    mem_we;
    logic [CW-1:0]           mem_waddr;
    logic [HEIGHT_BITS-1:0]  mem_wdata;
    logic [CW-1:0]           mem_raddr;
    logic [HEIGHT_BITS-1:0]  mem_rdata;

    logic                    in_accept;
    logic                    out_load;
    logic [PIECE_H_BITS-1:0] cfg_ext;
    logic [SWW-1:0]          sw_eff;
    logic [PIECE_H_BITS-1:0] w_in;
    logic [PIECE_H_BITS-1:0] h_in;
    logic                    fits_in;
    logic [CW-1:0]           span_addr;
    logic                    candidate;
    logic [TW-1:0]           top_sum;
    logic [HEIGHT_BITS-1:0]  peak_fin;

    sspp_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (WIDTH_MAX)
    ) u_cols (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign in_accept = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.place_x     = out_x_reg;
    assign rsp.place_y     = out_y_reg;
    assign rsp.peak_height = out_peak_reg;
    assign rsp.status      = out_status_reg;

    // Effective strip width: zero counts as one, anything past the store is clamped.
    always_comb
    begin
        cfg_ext = PIECE_H_BITS'(strip_width_reg);
        if (cfg_ext == '0)
        begin
            sw_eff = SWW'(1);
        end
        else if (cfg_ext > PIECE_H_BITS'(WIDTH_MAX))
        begin
            sw_eff = SWW'(WIDTH_MAX);
        end
        else
        begin
            sw_eff = SWW'(cfg_ext);
        end
    end

    always_comb
    begin
        w_in = req.rotated ? req.piece_height : PIECE_H_BITS'(req.piece_width);
        h_in = req.rotated ? PIECE_H_BITS'(req.piece_width) : req.piece_height;
        if (w_in == '0)
        begin
            w_in = PIECE_H_BITS'(1);
        end
        fits_in = (w_in <= PIECE_H_BITS'(sw_eff));
    end

    assign span_addr = best_reg + cnt_reg[CW-1:0];
    assign candidate = (SWW'(rd_addr_reg) <= lim_reg);
    assign top_sum   = TW'(base_reg) + TW'(h_reg);
    assign peak_fin  = (top_reg > peak_reg) ? top_reg : peak_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_valid_next   = 1'b0;
        rd_last_next    = 1'b0;
        rd_addr_next    = rd_addr_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        sw_next         = sw_reg;
        lim_next        = lim_reg;
        fits_next       = fits_reg;
        clear_next      = clear_reg;
        best_next       = best_reg;
        best_h_next     = best_h_reg;
        peak_next       = peak_reg;
        base_next       = base_reg;
        top_next        = top_reg;
        sat_next        = sat_reg;
        out_load        = 1'b0;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_peak_next   = out_peak_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg[CW-1:0];
        mem_wdata       = '0;
        mem_raddr       = cnt_reg[CW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + SWW'(1);
                if (cnt_reg == SWW'(WIDTH_MAX - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    clear_next = req.new_layout;
                    fits_next  = fits_in;
                    w_next     = SWW'(w_in);
                    h_next     = h_in;
                    sw_next    = sw_eff;
                    lim_next   = sw_eff - SWW'(w_in);
                    best_next  = '0;
                    peak_next  = '0;
                    base_next  = '0;
                    cnt_next   = '0;
                    state_next = req.new_layout ? S_CALC : S_SCAN;
                end
            end

            // Stream every strip column once: running peak and lowest fitting column.
            S_SCAN:
            begin
                if (cnt_reg < sw_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_addr_next  = cnt_reg[CW-1:0];
                    rd_last_next  = (cnt_reg == sw_reg - SWW'(1));
                    cnt_next      = cnt_reg + SWW'(1);
                end
                if (rd_valid_reg)
                begin
                    if (mem_rdata > peak_reg)
                    begin
                        peak_next = mem_rdata;
                    end
                    if (candidate && ((rd_addr_reg == '0) || (mem_rdata < best_h_reg)))
                    begin
                        best_next   = rd_addr_reg;
                        best_h_next = mem_rdata;
                    end
                    if (rd_last_reg)
                    begin
                        cnt_next   = '0;
                        state_next = fits_reg ? S_BASE : S_DONE;
                    end
                end
            end

            // Second pass over the chosen span only: its highest column is the base.
            S_BASE:
            begin
                mem_raddr = span_addr;
                if (cnt_reg < w_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_last_next  = (cnt_reg == w_reg - SWW'(1));
                    cnt_next      = cnt_reg + SWW'(1);
                end
                if (rd_valid_reg)
                begin
                    if (mem_rdata > base_reg)
                    begin
                        base_next = mem_rdata;
                    end
                    if (rd_last_reg)
                    begin
                        state_next = S_CALC;
                    end
                end
            end

            S_CALC:
            begin
                if (top_sum > TW'(HMAX))
                begin
                    top_next = HMAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    top_next = HEIGHT_BITS'(top_sum);
                    sat_next = 1'b0;
                end
                cnt_next   = '0;
                state_next = clear_reg ? S_FILL : S_WRITE;
            end

            S_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = span_addr;
                mem_wdata = top_reg;
                cnt_next  = cnt_reg + SWW'(1);
                if (cnt_reg == w_reg - SWW'(1))
                begin
                    state_next = S_DONE;
                end
            end

            // A new layout rewrites the whole store: the piece at the left edge if it fits, zero elsewhere.
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = (fits_reg && (cnt_reg < w_reg)) ? top_reg : '0;
                cnt_next  = cnt_reg + SWW'(1);
                if (cnt_reg == SWW'(WIDTH_MAX - 1))
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load = 1'b1;
                    if (fits_reg)
                    begin
                        out_x_next      = X_BITS'(best_reg);
                        out_y_next      = Y_BITS'(base_reg);
                        out_peak_next   = PEAK_BITS'(peak_fin);
                        out_status_next = sat_reg ? STATUS_SATURATED : STATUS_PLACED;
                    end
                    else
                    begin
                        out_x_next      = '0;
                        out_y_next      = '0;
                        out_peak_next   = PEAK_BITS'(peak_reg);
                        out_status_next = STATUS_TOO_WIDE;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cnt_reg         <= '0;
            rd_valid_reg    <= 1'b0;
            rd_last_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            strip_width_reg <= STRIP_W_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= rd_valid_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                strip_width_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= rd_addr_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        sw_reg         <= sw_next;
        lim_reg        <= lim_next;
        fits_reg       <= fits_next;
        clear_reg      <= clear_next;
        best_reg       <= best_next;
        best_h_reg     <= best_h_next;
        peak_reg       <= peak_next;
        base_reg       <= base_next;
        top_reg        <= top_next;
        sat_reg        <= sat_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_peak_reg   <= out_peak_next;
        out_status_reg <= out_status_next;
    end

    // The RAM is never written while an item could be reading it out of order.
    `ASSERT_ALWAYS(a_no_write_idle, clk, rst_n,
        !(mem_we && (state_reg == S_IDLE || state_reg == S_DONE)),
        "column write outside a write phase")
    `ASSERT_ALWAYS(a_read_phase, clk, rst_n,
        !rd_valid_reg || state_reg == S_SCAN || state_reg == S_BASE,
        "read data arrived outside a scan phase")
    `ASSERT_ALWAYS(a_span_in_strip, clk, rst_n,
        !(state_reg == S_CALC && fits_reg && !clear_reg) ||
        ((SWW+1)'(best_reg) + (SWW+1)'(w_reg) <= (SWW+1)'(sw_reg)),
        "chosen span leaves the strip")
    `ASSERT_ALWAYS(a_top_above_base, clk, rst_n,
        !(state_reg == S_DONE && fits_reg) || (top_reg >= base_reg),
        "new span height below its base")
    `ASSERT_NEXT(a_result_shown, clk, rst_n, out_load,
        out_valid_reg && state_reg == S_IDLE, "finished item not presented")

endmodule
